@@ rtl/tccw_pkg.sv @@
// ---------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console cell writer
// Screen geometry, character and item codes, and the structs that pass
// between the controller, the screen memory and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    // Screen geometry.
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int SCROLL_LAST = (ROWS - 1) * COLUMNS;
    localparam int AW          = $clog2(CELLS);

    // Field widths.
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;
    localparam int KIND_W = 2;

    // Limits one bit wider than the fields so that the full range fits.
    localparam logic [ROW_W:0] ROW_LIM = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0] COL_LIM = (COL_W + 1)'(COLUMNS);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Cell and attribute values after reset.
    localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
    localparam logic [7:0]        COLOR_RESET = 8'h07;

    // Request from the controller to the screen memory.
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } mem_req_t;

    // Result of one item.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_word;
    } result_t;

    // Linear cell address of a row and column.
    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        logic [AW-1:0] base;
        base = AW'(AW'(row) * AW'(COLUMNS));
        return AW'(base + AW'(col));
    endfunction

endpackage

`default_nettype wire

@@ rtl/tccw_ram.sv @@
// ---------------------------------------------------------------------------
// tccw_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered and appears
// in the cycle after the read request.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccw_ctrl.sv @@
// ---------------------------------------------------------------------------
// tccw_ctrl: cursor and screen memory sequencer
// Handles one item at a time: cursor updates, cell writes and reads, and
// the sweeps for reset blanking, clear screen and scrolling.
// ---------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tccw_pkg::KIND_W-1:0]    kind,
    input  wire logic [tccw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tccw_pkg::ROW_W-1:0]     target_row,
    input  wire logic [tccw_pkg::COL_W-1:0]     target_col,
    input  wire logic [7:0]                     color,
    output tccw_pkg::mem_req_t                  mem_req,
    input  wire logic [tccw_pkg::CELL_W-1:0]    mem_rdata,
    output logic                                res_valid,
    input  wire logic                           res_take,
    output tccw_pkg::result_t                   res
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int AW    = tccw_pkg::AW;
    localparam int ROW_W = tccw_pkg::ROW_W;
    localparam int COL_W = tccw_pkg::COL_W;

    logic [2:0]                    state_reg, state_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic [tccw_pkg::CELL_W-1:0]   cell_reg, cell_next;

    logic                          accept;
    logic [COL_W:0]                col_ext;
    logic [COL_W:0]                col_inc;
    logic [COL_W:0]                col_tab;
    logic                          at_last_row;
    logic                          target_ok;
    logic [tccw_pkg::CELL_W-1:0]   blank_cell;
    logic                          wrap;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign col_ext     = {1'b0, col_reg};
    assign col_inc     = col_ext + (COL_W + 1)'(1);
    assign col_tab     = (col_ext + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);
    assign at_last_row = (row_reg == ROW_W'(tccw_pkg::ROWS - 1));
    assign target_ok   = ({1'b0, target_row} < tccw_pkg::ROW_LIM) &&
                         ({1'b0, target_col} < tccw_pkg::COL_LIM);
    assign blank_cell  = {color, tccw_pkg::CH_SPACE};

    assign res_valid     = (state_reg == S_DONE);
    assign res.row       = row_reg;
    assign res.col       = col_reg;
    assign res.cell_word = cell_reg;

    // Next state, cursor and memory requests.
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        cell_next     = cell_reg;
        wrap          = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = cnt_reg;
        mem_req.wdata = blank_cell;
        mem_req.re    = 1'b0;
        mem_req.raddr = AW'(cnt_reg + AW'(tccw_pkg::COLUMNS));

        case (state_reg)
            // Blank every cell with the reset value after reset.
            S_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = tccw_pkg::BLANK_RESET;
                if (cnt_reg == AW'(tccw_pkg::CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    cell_next  = '0;
                    state_next = S_DONE;
                    case (kind)
                        tccw_pkg::KIND_PUT:
                        begin
                            if (char_code == tccw_pkg::CH_NEWLINE)
                            begin
                                wrap = 1'b1;
                            end
                            else if (char_code == tccw_pkg::CH_RETURN)
                            begin
                                col_next = '0;
                            end
                            else if (char_code == tccw_pkg::CH_TAB)
                            begin
                                col_next = col_tab[COL_W-1:0];
                                wrap     = (col_tab >= tccw_pkg::COL_LIM);
                            end
                            else if (char_code == tccw_pkg::CH_BACKSPACE)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next      = col_reg - COL_W'(1);
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = tccw_pkg::cell_addr(row_reg,
                                                                        col_next);
                                end
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = tccw_pkg::cell_addr(row_reg, col_reg);
                                mem_req.wdata = {color, char_code};
                                col_next      = col_inc[COL_W-1:0];
                                wrap          = (col_inc >= tccw_pkg::COL_LIM);
                            end

                            // Move to the next line, scrolling at the bottom.
                            if (wrap)
                            begin
                                col_next = '0;
                                if (at_last_row)
                                begin
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                        end

                        tccw_pkg::KIND_SET:
                        begin
                            if (target_ok)
                            begin
                                row_next = target_row;
                                col_next = target_col;
                            end
                        end

                        tccw_pkg::KIND_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = S_FILL;
                        end

                        default:
                        begin
                            if (target_ok)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = tccw_pkg::cell_addr(target_row,
                                                                    target_col);
                                state_next    = S_READ;
                            end
                        end
                    endcase
                end
            end

            // Registered read data is available now.
            S_READ:
            begin
                cell_next  = mem_rdata;
                state_next = S_DONE;
            end

            // Copy each cell from one row below: read ahead, write behind.
            S_SCROLL:
            begin
                mem_req.we    = (cnt_reg != '0);
                mem_req.waddr = AW'(cnt_reg - AW'(1));
                mem_req.wdata = mem_rdata;
                if (cnt_reg == AW'(tccw_pkg::SCROLL_LAST))
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    mem_req.re = 1'b1;
                    cnt_next   = cnt_reg + AW'(1);
                end
            end

            // Blank cells from the counter to the end of the buffer.
            S_FILL:
            begin
                mem_req.we = 1'b1;
                if (cnt_reg == AW'(tccw_pkg::CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            // Hold the result until the output register takes it.
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result cell word.
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

endmodule

`default_nettype wire

@@ rtl/text_console_cell_writer_top.sv @@
// ---------------------------------------------------------------------------
// text_console_cell_writer_top: character-cell text console
// Keeps a cursor and a screen buffer of attribute/character cells; puts
// characters, moves the cursor, clears the screen and reads cells.
//
//   Channel   Direction  Handshake           Contents
//   input     in         in_valid/in_stall   kind, char_code, target_row/col
//   output    out        out_valid/out_stall cursor_row, cursor_col, cell_value
//   config    in         cfg_valid/cfg_ready text_color
//
// The controller handles a put or set-cursor in its idle state and hands the
// result on from its done state; a read inside the screen first waits in
// its read state for the registered memory data. A scroll copies each row
// up one through the memory port and then blanks the bottom row; a clear
// blanks the whole buffer. After reset the buffer is blanked before the
// first input transaction is accepted; configuration writes are always taken.
// A stalled output register holds its result while the next item runs.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tccw_pkg::KIND_W-1:0]   kind,
    input  wire logic [tccw_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tccw_pkg::ROW_W-1:0]    target_row,
    input  wire logic [tccw_pkg::COL_W-1:0]    target_col,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [tccw_pkg::ROW_W-1:0]    cursor_row,
    output logic      [tccw_pkg::COL_W-1:0]    cursor_col,
    output logic      [tccw_pkg::CELL_W-1:0]   cell_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [7:0]                    text_color
);

    logic                        out_valid_reg;
    tccw_pkg::result_t           out_res_reg;
    logic [7:0]                  color_reg;
    logic                        res_valid;
    logic                        res_take;
    tccw_pkg::result_t           res;
    tccw_pkg::mem_req_t          mem_req;
    logic [tccw_pkg::CELL_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    // Attribute register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tccw_pkg::COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_reg <= text_color;
        end
    end

    // Controller.
    tccw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .color      (color_reg),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Screen buffer.
    tccw_ram #(
        .DEPTH (tccw_pkg::CELLS),
        .WIDTH (tccw_pkg::CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Output register: a transaction leaves when out_stall is low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_row = out_res_reg.row;
    assign cursor_col = out_res_reg.col;
    assign cell_value = out_res_reg.cell_word;

`ifndef SYNTHESIS
    // The reported cursor always lies on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, cursor_row} < tccw_pkg::ROW_LIM) &&
                      ({1'b0, cursor_col} < tccw_pkg::COL_LIM))
        else $error("cursor outside the screen");

    // An accepted item keeps the controller busy, so items are never taken back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("controller accepted back-to-back items");

    // A new output transaction only appears after a controller handoff.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(res_valid))
        else $error("output became valid without a result");

    // The controller never reads and writes the same cell in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("memory read and write collide");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for text_console_cell_writer_top
// Drives put, set-cursor, clear and read transactions through the input
// channel. It runs a cycle-free model of the screen buffer and cursor, and
// compares every output transaction field by field against it. Directed
// cases cover the screen edges, the control characters, scrolling and
// clearing. Random traffic follows, under three idling mixes and several
// text colors, with one long output hold-off that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import tccw_pkg::*;

    // Cycles without any transaction before the run is abandoned. The reset
    // clearing pass, a scroll or clear, and the long output hold-off all fit
    // well inside this.
    localparam int QUIET_LIMIT = 20000;
    // Settling time after the last result: about one scroll.
    localparam int TAIL_CYCLES = 2200;
    localparam int HOLD_CYCLES = 400;

    // One result transaction as the model expects it.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] word;
    } console_reply_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [KIND_W-1:0]   kind       = KIND_PUT;
    logic [CHAR_W-1:0]   char_code  = '0;
    logic [ROW_W-1:0]    target_row = '0;
    logic [COL_W-1:0]    target_col = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic [CELL_W-1:0]   cell_value;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [7:0]          text_color = COLOR_RESET;

    // Model state: screen buffer, cursor and attribute byte.
    logic [CELL_W-1:0]   model_screen [CELLS];
    int unsigned         model_row;
    int unsigned         model_col;
    logic [7:0]          model_attr;

    console_reply_t      pending_replies [$];
    int                  error_count = 0;
    int                  quiet_cycles = 0;
    int                  tx_idle_pct = 31;
    int                  rx_idle_pct = 58;
    int                  hold_left = 0;

    text_console_cell_writer_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .char_code  (char_code),
        .target_row (target_row),
        .target_col (target_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_value (cell_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .text_color (text_color)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Screen model
    // -----------------------------------------------------------------------

    function automatic void reset_screen_model();
        for (int i = 0; i < CELLS; i++)
            model_screen[i] = BLANK_RESET;
        model_row  = 0;
        model_col  = 0;
        model_attr = COLOR_RESET;
    endfunction

    // Cursor to column 0 of the next row; at the bottom the screen moves up
    // one row and the bottom row is blanked in the current attribute.
    function automatic void line_feed();
        model_col = 0;
        model_row++;
        if (model_row >= ROWS)
        begin
            for (int i = 0; i < SCROLL_LAST; i++)
                model_screen[i] = model_screen[i + COLUMNS];
            for (int i = SCROLL_LAST; i < CELLS; i++)
                model_screen[i] = {model_attr, CH_SPACE};
            model_row = ROWS - 1;
        end
    endfunction

    // Apply one input transaction and return the result it must produce.
    function automatic console_reply_t apply_console_item(
        input logic [KIND_W-1:0] k,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  tr,
        input logic [COL_W-1:0]  tc
    );
        console_reply_t reply;
        bit             in_range;
        reply.word = '0;
        in_range = (tr < ROWS) && (tc < COLUMNS);
        case (k)
            KIND_PUT:
            begin
                if (ch == CH_NEWLINE)
                    line_feed();
                else if (ch == CH_RETURN)
                    model_col = 0;
                else if (ch == CH_TAB)
                begin
                    model_col = (model_col + 4) & ~32'd3;
                    if (model_col >= COLUMNS)
                        line_feed();
                end
                else if (ch == CH_BACKSPACE)
                begin
                    // Nothing happens at the left edge.
                    if (model_col > 0)
                    begin
                        model_col--;
                        model_screen[model_row * COLUMNS + model_col] = {model_attr, CH_SPACE};
                    end
                end
                else
                begin
                    model_screen[model_row * COLUMNS + model_col] = {model_attr, ch};
                    model_col++;
                    if (model_col >= COLUMNS)
                        line_feed();
                end
            end
            KIND_SET:
            begin
                // Out-of-range positions leave the cursor where it is.
                if (in_range)
                begin
                    model_row = tr;
                    model_col = tc;
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    model_screen[i] = {model_attr, CH_SPACE};
                model_row = 0;
                model_col = 0;
            end
            default:
            begin
                if (in_range)
                    reply.word = model_screen[int'(tr) * COLUMNS + int'(tc)];
            end
        endcase
        reply.row = ROW_W'(model_row);
        reply.col = COL_W'(model_col);
        return reply;
    endfunction

    // -----------------------------------------------------------------------
    // Output side: stall generation, result checking and the watchdog
    // -----------------------------------------------------------------------

    // A hold-off, when requested, overrides the random stall pattern.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // Each accepted result transaction is matched against the oldest
    // expectation.
    always @(posedge clk)
    begin : check_results
        console_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("result with nothing expected", cursor_row, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (cursor_row !== want.row)
                    report_mismatch("cursor_row", cursor_row, want.row);
                if (cursor_col !== want.col)
                    report_mismatch("cursor_col", cursor_col, want.col);
                if (cell_value !== want.word)
                    report_mismatch("cell_value", cell_value, want.word);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("** text_console_cell_writer_top: FAILED **");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------

    // Offer one item after a random gap and wait until it is accepted. The
    // valid stays high afterwards so back-to-back items need no extra edge.
    task automatic send_item(
        input logic [KIND_W-1:0] k,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  tr,
        input logic [COL_W-1:0]  tc
    );
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        char_code  <= ch;
        target_row <= tr;
        target_col <= tc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(apply_console_item(k, ch, tr, tc));
    endtask

    // Stop offering and wait for every expected result.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_text_color(input logic [7:0] attr);
        cfg_valid  <= 1'b1;
        text_color <= attr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        model_attr = attr;
    endtask

    // Mostly printable text with control characters mixed in; cursor moves
    // lean toward the bottom rows so that scrolling happens regularly, and
    // half the reads look at the cursor row where text was just written.
    task automatic send_random_item();
        int unsigned       pick;
        int unsigned       sub;
        logic [KIND_W-1:0] k;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  tr;
        logic [COL_W-1:0]  tc;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom);
        tr   = ROW_W'($urandom);
        tc   = COL_W'($urandom);
        if (pick < 2)
            k = KIND_CLEAR;
        else if (pick < 57)
        begin
            k = KIND_PUT;
            if (sub < 10)
                ch = CH_NEWLINE;
            else if (sub < 15)
                ch = CH_RETURN;
            else if (sub < 23)
                ch = CH_TAB;
            else if (sub < 31)
                ch = CH_BACKSPACE;
        end
        else if (pick < 75)
        begin
            k = KIND_SET;
            if (sub < 20)
                tr = ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
            else if (sub < 85)
                tr = ROW_W'($urandom_range(0, ROWS - 1));
            if (sub < 85)
                tc = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        else
        begin
            k = KIND_READ;
            if (sub < 50)
                tr = ROW_W'(model_row);
            else if (sub < 85)
                tr = ROW_W'($urandom_range(0, ROWS - 1));
            if (sub < 85)
                tc = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        send_item(k, ch, tr, tc);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // The buffer comes out of reset blank, and reads off the screen give 0.
    task automatic test_reset_contents();
        send_item(KIND_READ, '0, 5'd0, 7'd0);
        send_item(KIND_READ, '0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_item(KIND_READ, '1, '1, '1);
        drain();
    endtask

    // Printable extremes and every control character, including backspace
    // at the left edge.
    task automatic test_put_characters();
        write_text_color(8'hFF);
        send_item(KIND_PUT, 8'hFF, '0, '0);
        send_item(KIND_PUT, 8'h00, '0, '0);
        send_item(KIND_PUT, 8'h41, '0, '0);
        send_item(KIND_PUT, CH_TAB, '0, '0);
        send_item(KIND_PUT, CH_BACKSPACE, '0, '0);
        send_item(KIND_PUT, CH_RETURN, '0, '0);
        send_item(KIND_PUT, CH_BACKSPACE, '0, '0);
        send_item(KIND_PUT, CH_NEWLINE, '0, '0);
        send_item(KIND_READ, '0, 5'd0, 7'd0);
        send_item(KIND_READ, '0, 5'd0, 7'd3);
        drain();
    endtask

    // The last valid position is taken; rows and columns past the edge are
    // ignored.
    task automatic test_set_cursor();
        send_item(KIND_SET, '0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_item(KIND_SET, '0, ROW_W'(ROWS), 7'd0);
        send_item(KIND_SET, '0, 5'd0, COL_W'(COLUMNS));
        send_item(KIND_SET, '0, '1, '1);
        drain();
    endtask

    // A character in the bottom-right cell and a tab near the right edge
    // both wrap past the last row and scroll.
    task automatic test_scroll();
        write_text_color(8'h00);
        send_item(KIND_PUT, 8'h5A, '0, '0);
        send_item(KIND_READ, '0, ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
        send_item(KIND_READ, '0, ROW_W'(ROWS - 1), 7'd0);
        send_item(KIND_SET, '0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 2));
        send_item(KIND_PUT, CH_TAB, '0, '0);
        send_item(KIND_READ, '0, ROW_W'(ROWS - 3), COL_W'(COLUMNS - 1));
        drain();
    endtask

    task automatic test_clear();
        send_item(KIND_CLEAR, '0, '0, '0);
        send_item(KIND_READ, '0, ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
        drain();
    endtask

    // Every earlier test ends drained, so the color can change right away.
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct,
                                       input logic [7:0] attr);
        write_text_color(attr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count)
            send_random_item();
        drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block backs up and stalls its input.
    task automatic test_output_backpressure();
        write_text_color(COLOR_RESET);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        repeat (30)
            send_random_item();
        drain();
    endtask

    initial
    begin
        reset_screen_model();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_put_characters();
        test_set_cursor();
        test_scroll();
        test_clear();
        test_random_traffic(300, 31, 58, 8'($urandom));
        test_random_traffic(300, 58, 31, 8'h00);
        test_random_traffic(270, 0, 0, 8'hFF);
        test_output_backpressure();

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("** text_console_cell_writer_top: PASSED **");
        else
            $display("** text_console_cell_writer_top: FAILED **");
        $finish;
    end

endmodule

@@ text_console_cell_writer_top.f @@
rtl/tccw_pkg.sv
rtl/tccw_ram.sv
rtl/tccw_ctrl.sv
rtl/text_console_cell_writer_top.sv
tb/sv/testbench.sv
